>>> rtl/carp_pkg.sv
// Package for the cascaded angle/rate PID: shared types, fixed-point constants,
// the microcode ROM and the saturation helper.
// No dependencies.
package carp_pkg;

    localparam int ACC_W    = 67;
    localparam int PROD_W   = 66;
    localparam int OPND_W   = 33;
    localparam int STEP_W   = 4;
    localparam int GAIN_N   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int INT_LIMIT = 500;

    localparam logic [STEP_W-1:0] STEP_IDLE = '0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KD = 3'd5;

    // 0.001 in Q0.32, low-pass weights in Q16, 1/dt
    localparam logic signed [OPND_W-1:0] K_DT    = 33'sd4294967;
    localparam logic signed [OPND_W-1:0] K_LP04  = 33'sd26214;
    localparam logic signed [OPND_W-1:0] K_LP06  = 33'sd39322;
    localparam logic signed [OPND_W-1:0] K_INVDT = 33'sd1000;

    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc ACC_S32_MAX = t_acc'(32'sh7FFF_FFFF);
    localparam t_acc ACC_S32_MIN = t_acc'(32'sh8000_0000);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ERR_O,
        OP_LOAD,
        OP_ADD,
        OP_FILT_O,
        OP_INTEG_O,
        OP_TGT,
        OP_FILT_I,
        OP_INTEG_I,
        OP_DRIVE
    } t_op;

    typedef enum logic {
        SH_NONE,
        SH_FRAC
    } t_shift;

    typedef enum logic [2:0] {
        A_ERR,
        A_OSUM,
        A_OFILT,
        A_NRATE,
        A_ISUM,
        A_IFILT,
        A_DRATE
    } t_asel;

    typedef enum logic [3:0] {
        B_KP_O,
        B_KI_O,
        B_KD_O,
        B_KP_I,
        B_KI_I,
        B_KD_I,
        B_DT,
        B_LP04,
        B_LP06,
        B_INVDT
    } t_bsel;

    typedef enum logic [1:0] {
        NX_SEQ,
        NX_WAIT_IN,
        NX_WAIT_OUT
    } t_next;

    typedef struct packed {
        t_op    op;
        t_shift sh;
        t_asel  a;
        t_bsel  b;
        t_next  nx;
    } t_uword;

    function automatic t_uword uw(t_op op, t_shift sh, t_asel a, t_bsel b, t_next nx);
        t_uword w;
        w.op = op;
        w.sh = sh;
        w.a  = a;
        w.b  = b;
        w.nx = nx;
        return w;
    endfunction

    // product issued in step k is consumed by the op of step k+1
    function automatic t_uword ucode(logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            4'd0:    w = uw(OP_NOP,     SH_NONE, A_ERR,   B_DT,    NX_WAIT_IN);
            4'd1:    w = uw(OP_ERR_O,   SH_NONE, A_OFILT, B_LP04,  NX_SEQ);
            4'd2:    w = uw(OP_LOAD,    SH_NONE, A_NRATE, B_LP06,  NX_SEQ);
            4'd3:    w = uw(OP_FILT_O,  SH_NONE, A_ERR,   B_DT,    NX_SEQ);
            4'd4:    w = uw(OP_INTEG_O, SH_NONE, A_ERR,   B_KP_O,  NX_SEQ);
            4'd5:    w = uw(OP_LOAD,    SH_FRAC, A_OSUM,  B_KI_O,  NX_SEQ);
            4'd6:    w = uw(OP_ADD,     SH_FRAC, A_OFILT, B_KD_O,  NX_SEQ);
            4'd7:    w = uw(OP_ADD,     SH_FRAC, A_ERR,   B_DT,    NX_SEQ);
            4'd8:    w = uw(OP_TGT,     SH_NONE, A_DRATE, B_INVDT, NX_SEQ);
            4'd9:    w = uw(OP_FILT_I,  SH_NONE, A_ERR,   B_DT,    NX_SEQ);
            4'd10:   w = uw(OP_INTEG_I, SH_NONE, A_ERR,   B_KP_I,  NX_SEQ);
            4'd11:   w = uw(OP_LOAD,    SH_FRAC, A_ISUM,  B_KI_I,  NX_SEQ);
            4'd12:   w = uw(OP_ADD,     SH_FRAC, A_IFILT, B_KD_I,  NX_SEQ);
            4'd13:   w = uw(OP_ADD,     SH_FRAC, A_ERR,   B_DT,    NX_SEQ);
            4'd14:   w = uw(OP_DRIVE,   SH_NONE, A_ERR,   B_DT,    NX_WAIT_OUT);
            default: w = uw(OP_NOP,     SH_NONE, A_ERR,   B_DT,    NX_WAIT_OUT);
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(t_acc v);
        t_acc r;
        if (v > ACC_S32_MAX) begin
            r = ACC_S32_MAX;
        end else if (v < ACC_S32_MIN) begin
            r = ACC_S32_MIN;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

endpackage

>>> rtl/cascaded_angle_rate_pid.sv
// Top level of the cascaded angle/rate PID for one axis.
// Depends on carp_pkg (types, constants, microcode ROM).

// An idle step takes the input beat, then 14 microcode steps drive a single 33x33
// signed multiplier and a 67-bit accumulator. No new beat is taken until the
// result of the last one has been registered, and none while a finished result is
// still held by a stalled output. Gains are written through the plain write port;
// the user must write them only while the block is idle, and the block itself has
// no logic that enforces it. clear_integrals zeroes both integral sums at accept.

module cascaded_angle_rate_pid #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [carp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [31:0]                  i_angle_setpoint,
    input  logic signed [31:0]                  i_measured_angle,
    input  logic signed [31:0]                  i_measured_rate,
    input  logic                                i_clear_integrals,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [31:0]                  o_drive_output,
    output logic signed [31:0]                  o_rate_target
);

    localparam longint LIM_RAW = longint'(carp_pkg::INT_LIMIT) << FRAC_BITS;
    localparam logic signed [31:0] INT_LIM =
        (LIM_RAW > 64'sd2147483647) ? 32'sh7FFF_FFFF : LIM_RAW[31:0];
    localparam carp_pkg::t_acc ACC_LIM_P = carp_pkg::t_acc'(INT_LIM);
    localparam carp_pkg::t_acc ACC_LIM_N = -carp_pkg::t_acc'(INT_LIM);

    // sequencer
    logic [carp_pkg::STEP_W-1:0] r_step;
    logic [carp_pkg::STEP_W-1:0] n_step;
    carp_pkg::t_uword            w_uw;
    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_drive;

    // config and state
    logic [31:0]        r_gain [carp_pkg::GAIN_N];
    logic signed [31:0] r_osum;
    logic signed [31:0] r_ofilt;
    logic signed [31:0] r_isum;
    logic signed [31:0] r_ifilt;
    logic signed [31:0] r_prev;

    // datapath
    logic signed [31:0]                   r_sp;
    logic signed [31:0]                   r_ang;
    logic signed [31:0]                   r_rate;
    logic signed [31:0]                   r_err;
    logic signed [31:0]                   r_tgt;
    logic signed [carp_pkg::PROD_W-1:0]   r_prod;
    carp_pkg::t_acc                       r_acc;
    logic                                 r_out_valid;
    logic signed [31:0]                   r_drive_out;
    logic signed [31:0]                   r_tgt_out;

    logic signed [carp_pkg::OPND_W-1:0] w_rate_x;
    logic signed [carp_pkg::OPND_W-1:0] w_a;
    logic signed [carp_pkg::OPND_W-1:0] w_b;
    carp_pkg::t_acc                     w_prod_x;
    carp_pkg::t_acc                     w_prod_sh;
    carp_pkg::t_acc                     w_integ_raw;
    logic signed [31:0]                 w_integ;
    logic signed [31:0]                 w_tgt;
    logic signed [31:0]                 w_err_i;

    always_comb begin
        w_uw       = carp_pkg::ucode(r_step);
        w_in_acc   = i_valid && (w_uw.nx == carp_pkg::NX_WAIT_IN);
        w_out_free = !r_out_valid || !i_stall;
        w_drive    = (w_uw.op == carp_pkg::OP_DRIVE) && w_out_free;
        case (w_uw.nx)
            carp_pkg::NX_SEQ:      n_step = r_step + 4'd1;
            carp_pkg::NX_WAIT_IN:  n_step = w_in_acc ? r_step + 4'd1 : r_step;
            carp_pkg::NX_WAIT_OUT: n_step = w_out_free ? carp_pkg::STEP_IDLE : r_step;
            default:               n_step = carp_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= carp_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // operand select
    always_comb begin
        w_rate_x = {r_rate[31], r_rate};
        case (w_uw.a)
            carp_pkg::A_ERR:   w_a = {r_err[31], r_err};
            carp_pkg::A_OSUM:  w_a = {r_osum[31], r_osum};
            carp_pkg::A_OFILT: w_a = {r_ofilt[31], r_ofilt};
            carp_pkg::A_NRATE: w_a = -w_rate_x;
            carp_pkg::A_ISUM:  w_a = {r_isum[31], r_isum};
            carp_pkg::A_IFILT: w_a = {r_ifilt[31], r_ifilt};
            carp_pkg::A_DRATE: w_a = {r_prev[31], r_prev} - w_rate_x;
            default:           w_a = '0;
        endcase
        case (w_uw.b)
            carp_pkg::B_KP_O:  w_b = {1'b0, r_gain[carp_pkg::REG_OUTER_KP]};
            carp_pkg::B_KI_O:  w_b = {1'b0, r_gain[carp_pkg::REG_OUTER_KI]};
            carp_pkg::B_KD_O:  w_b = {1'b0, r_gain[carp_pkg::REG_OUTER_KD]};
            carp_pkg::B_KP_I:  w_b = {1'b0, r_gain[carp_pkg::REG_INNER_KP]};
            carp_pkg::B_KI_I:  w_b = {1'b0, r_gain[carp_pkg::REG_INNER_KI]};
            carp_pkg::B_KD_I:  w_b = {1'b0, r_gain[carp_pkg::REG_INNER_KD]};
            carp_pkg::B_DT:    w_b = carp_pkg::K_DT;
            carp_pkg::B_LP04:  w_b = carp_pkg::K_LP04;
            carp_pkg::B_LP06:  w_b = carp_pkg::K_LP06;
            carp_pkg::B_INVDT: w_b = carp_pkg::K_INVDT;
            default:           w_b = '0;
        endcase
    end

    // post-multiply arithmetic
    always_comb begin
        w_prod_x  = carp_pkg::t_acc'(r_prod);
        w_prod_sh = (w_uw.sh == carp_pkg::SH_FRAC) ? (w_prod_x >>> FRAC_BITS) : w_prod_x;
        w_integ_raw = carp_pkg::t_acc'((w_uw.op == carp_pkg::OP_INTEG_O) ? r_osum : r_isum)
                    + (w_prod_x >>> 32);
        if (w_integ_raw > ACC_LIM_P) begin
            w_integ = INT_LIM;
        end else if (w_integ_raw < ACC_LIM_N) begin
            w_integ = -INT_LIM;
        end else begin
            w_integ = w_integ_raw[31:0];
        end
        w_tgt   = carp_pkg::sat32(r_acc);
        w_err_i = carp_pkg::sat32(carp_pkg::t_acc'(w_tgt) - carp_pkg::t_acc'(r_rate));
    end

    // gains and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < carp_pkg::GAIN_N; k++) begin
                r_gain[k] <= '0;
            end
            r_osum      <= '0;
            r_ofilt     <= '0;
            r_isum      <= '0;
            r_ifilt     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx < 3'(carp_pkg::GAIN_N))) begin
                r_gain[i_cfg_idx] <= i_cfg_data;
            end
            if (w_in_acc && i_clear_integrals) begin
                r_osum <= '0;
                r_isum <= '0;
            end
            case (w_uw.op)
                carp_pkg::OP_FILT_O:  r_ofilt <= carp_pkg::sat32((r_acc + w_prod_x) >>> 16);
                carp_pkg::OP_INTEG_O: r_osum  <= w_integ;
                carp_pkg::OP_FILT_I: begin
                    r_ifilt <= carp_pkg::sat32((carp_pkg::t_acc'(r_ifilt) + w_prod_x) >>> 1);
                    r_prev  <= r_rate;
                end
                carp_pkg::OP_INTEG_I: r_isum  <= w_integ;
                default: ;
            endcase
            if (w_drive) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        if (w_in_acc) begin
            r_sp   <= i_angle_setpoint;
            r_ang  <= i_measured_angle;
            r_rate <= i_measured_rate;
        end
        case (w_uw.op)
            carp_pkg::OP_ERR_O:
                r_err <= carp_pkg::sat32(carp_pkg::t_acc'(r_sp) - carp_pkg::t_acc'(r_ang));
            carp_pkg::OP_LOAD: r_acc <= w_prod_sh;
            carp_pkg::OP_ADD:  r_acc <= r_acc + w_prod_sh;
            carp_pkg::OP_TGT: begin
                r_tgt <= w_tgt;
                r_err <= w_err_i;
            end
            default: ;
        endcase
        if (w_drive) begin
            r_drive_out <= carp_pkg::sat32(r_acc);
            r_tgt_out   <= r_tgt;
        end
    end

    assign o_stall        = (w_uw.nx != carp_pkg::NX_WAIT_IN);
    assign o_valid        = r_out_valid;
    assign o_drive_output = r_drive_out;
    assign o_rate_target  = r_tgt_out;

endmodule

>>> rtl/carp_checker.sv
// Port-level checker for cascaded_angle_rate_pid, bound to the top level.
// Depends only on the top level's handshake and result ports.
module carp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic signed [31:0]              o_drive_output,
    input  logic signed [31:0]              o_rate_target
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive_output) && $stable(o_rate_target))
        else $error("output beat changed while stalled");

    // one item at a time: input closes right after a beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken twice in a row");

    // no result can follow an input beat in the next cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result appeared too early");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind cascaded_angle_rate_pid carp_checker u_carp_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for cascaded_angle_rate_pid: a scoreboard class holds a fixed-point
// model of both PID loops, plain tasks drive gains and input beats, and an always block drives output back-pressure.
// Depends on carp_pkg and cascaded_angle_rate_pid.

module testbench;

    localparam int FRAC_BITS = 16;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint DT_Q32 = 4294967;
    localparam longint LP_KEEP = 26214;
    localparam longint LP_TAKE = 39322;
    localparam longint RATE_TO_DERIV = 1000;
    localparam longint ISUM_LIMIT = 500;
    localparam logic [carp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [carp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 200;

    typedef enum {GAINS_MODEST, GAINS_ANY, GAINS_SUBUNIT, GAINS_EDGES} t_gain_mode;

    typedef struct {
        int drive;
        int target;
    } t_pid_result;

    class pid_scoreboard;
        bit [31:0]   gain [carp_pkg::GAIN_N];
        longint      outer_isum, outer_filt, inner_isum, inner_filt, prev_rate;
        t_pid_result pending [$];
        int          mismatches;

        function void set_gain(logic [carp_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
            if (idx < carp_pkg::GAIN_N) gain[idx] = val;
        endfunction

        function longint sat(longint v);
            if (v > S32_MAX) return S32_MAX;
            if (v < S32_MIN) return S32_MIN;
            return v;
        endfunction

        function longint scale(longint v, bit [31:0] g);
            return (v * longint'({32'b0, g})) >>> FRAC_BITS;
        endfunction

        function longint integrate(longint sum, longint err);
            longint lim;
            lim = ISUM_LIMIT << FRAC_BITS;
            if (lim > S32_MAX) lim = S32_MAX;
            sum = sum + ((err * DT_Q32) >>> 32);
            if (sum > lim) sum = lim;
            if (sum < -lim) sum = -lim;
            return sum;
        endfunction

        function void note_input(int sp, int ang, int rate, bit clr);
            longint      err, p, i, d, target, drive, r;
            t_pid_result res;
            r = rate;
            if (clr) begin
                outer_isum = 0;
                inner_isum = 0;
            end
            // angle loop
            err = sat(longint'(sp) - longint'(ang));
            p = scale(err, gain[carp_pkg::REG_OUTER_KP]);
            outer_isum = integrate(outer_isum, err);
            i = scale(outer_isum, gain[carp_pkg::REG_OUTER_KI]);
            outer_filt = sat((outer_filt * LP_KEEP + (-r) * LP_TAKE) >>> 16);
            d = scale(outer_filt, gain[carp_pkg::REG_OUTER_KD]);
            target = sat(p + i + d);
            // rate loop
            err = sat(target - r);
            p = scale(err, gain[carp_pkg::REG_INNER_KP]);
            inner_isum = integrate(inner_isum, err);
            i = scale(inner_isum, gain[carp_pkg::REG_INNER_KI]);
            inner_filt = sat((inner_filt + (prev_rate - r) * RATE_TO_DERIV) >>> 1);
            prev_rate = r;
            d = scale(inner_filt, gain[carp_pkg::REG_INNER_KD]);
            drive = sat(p + i + d);
            res.drive = int'(drive);
            res.target = int'(target);
            pending.push_back(res);
        endfunction

        function void check_result(logic signed [31:0] got_drive, logic signed [31:0] got_target);
            t_pid_result want;
            if (pending.size() == 0) begin
                $error("output beat with no expected result: drive_output %0d rate_target %0d",
                       got_drive, got_target);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got_drive !== want.drive) begin
                $error("drive_output: expected %0d, got %0d", want.drive, got_drive);
                mismatches++;
            end
            if (got_target !== want.target) begin
                $error("rate_target: expected %0d, got %0d", want.target, got_target);
                mismatches++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [carp_pkg::CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [31:0]                         i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic signed [31:0]                  i_angle_setpoint = '0;
    logic signed [31:0]                  i_measured_angle = '0;
    logic signed [31:0]                  i_measured_rate = '0;
    logic                                i_clear_integrals = 1'b0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [31:0]                  o_drive_output;
    logic signed [31:0]                  o_rate_target;

    pid_scoreboard sb = new();
    bit [31:0]     gain_plan [carp_pkg::GAIN_N];
    bit            tx_calm = 1'b0;
    bit            rx_calm = 1'b0;
    int            rx_wait = 0;

    cascaded_angle_rate_pid #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_angle_setpoint(i_angle_setpoint),
        .i_measured_angle(i_measured_angle),
        .i_measured_rate(i_measured_rate),
        .i_clear_integrals(i_clear_integrals),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_drive_output(o_drive_output),
        .o_rate_target(o_rate_target)
    );

    always #1 i_clk = ~i_clk;

    // output side: after each beat, hold stall on pending valid until a wait drawn per beat has run down
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_drive_output, o_rate_target);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
                i_stall <= (rx_wait != 0);
            end else if (o_valid && i_stall) begin
                rx_wait = rx_wait - 1;
                if (rx_wait <= 0) i_stall <= 1'b0;
            end
        end
    end

    function automatic bit [31:0] draw_edge();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic bit [31:0] draw_gain(t_gain_mode mode);
        case (mode)
            GAINS_MODEST: return $urandom_range(0, 8 << FRAC_BITS);
            GAINS_ANY: return $urandom;
            GAINS_SUBUNIT: return $urandom_range(0, 1 << FRAC_BITS);
            default: begin
                case ($urandom_range(0, 2))
                    0: return 32'h0;
                    1: return 32'hFFFF_FFFF;
                    default: return $urandom_range(0, 4 << FRAC_BITS);
                endcase
            end
        endcase
    endfunction

    // writes all six gains, then one out-of-range index that must be ignored
    task automatic load_gains();
        logic [carp_pkg::CFG_IDX_W-1:0] spare;
        for (int k = 0; k < carp_pkg::GAIN_N; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= carp_pkg::REG_OUTER_KP + k[carp_pkg::CFG_IDX_W-1:0];
            i_cfg_data <= gain_plan[k];
            @(posedge i_clk);
            sb.set_gain(carp_pkg::REG_OUTER_KP + k[carp_pkg::CFG_IDX_W-1:0], gain_plan[k]);
        end
        spare = $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
        i_cfg_idx <= spare;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        sb.set_gain(spare, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_gains(bit [31:0] val);
        for (int k = 0; k < carp_pkg::GAIN_N; k++) gain_plan[k] = val;
    endtask

    task automatic send_item(logic [31:0] sp, logic [31:0] ang, logic [31:0] rate, logic clr);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_angle_setpoint <= sp;
        i_measured_angle <= ang;
        i_measured_rate <= rate;
        i_clear_integrals <= clr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(sp, ang, rate, clr);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic edge_items();
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1'b0);
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    endtask

    initial begin
        int          sent, ep_len, r;
        logic [31:0] base_sp, base_err, sp, ang, rate;
        logic        clr_first;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains: results stay zero while the state still moves
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        drain();

        fill_gains(32'h0001_0000);
        load_gains();
        edge_items();
        drain();

        fill_gains(32'hFFFF_FFFF);
        load_gains();
        edge_items();
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int k = 0; k < carp_pkg::GAIN_N; k++) begin
                gain_plan[k] = draw_gain(t_gain_mode'(ph % 4));
            end
            load_gains();
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // episode: setpoint and error mostly held, so the integrals wind toward the clamp
                ep_len = $urandom_range(4, 40);
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: base_sp = $urandom_range(0, 360 << FRAC_BITS) - (180 << FRAC_BITS);
                    1: base_sp = $urandom;
                    default: base_sp = draw_edge();
                endcase
                case ($urandom_range(0, 2))
                    0: base_err = $urandom_range(0, 40 << FRAC_BITS) - (20 << FRAC_BITS);
                    1: base_err = $urandom_range(0, 6000 << FRAC_BITS) - (3000 << FRAC_BITS);
                    default: base_err = $urandom;
                endcase
                clr_first = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < ep_len; k++) begin
                    r = $urandom_range(0, 19);
                    if (r < 15) begin
                        sp = base_sp;
                        ang = base_sp - base_err + $urandom_range(0, 2 << FRAC_BITS)
                              - (1 << FRAC_BITS);
                        rate = $urandom_range(0, 1000 << FRAC_BITS) - (500 << FRAC_BITS);
                    end else if (r < 18) begin
                        sp = $urandom;
                        ang = $urandom;
                        rate = $urandom;
                    end else begin
                        sp = draw_edge();
                        ang = draw_edge();
                        rate = draw_edge();
                    end
                    send_item(sp, ang, rate, (k == 0) ? clr_first : ($urandom_range(0, 63) == 0));
                    sent++;
                end
            end
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

>>> files.f
rtl/carp_pkg.sv
rtl/cascaded_angle_rate_pid.sv
rtl/carp_checker.sv
tb/testbench.sv
